[rtl/ccs_pkg.sv]
// shared types, constants and saturation helpers for the cluster sum block
package ccs_pkg;

  localparam int GRID_SIDE = 7;
  localparam int AMP_WIDTH = 16;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int RC_W      = $clog2(GRID_SIDE);
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int S1_W      = 16;
  localparam int SUM_W     = 22;
  localparam int FLAG_W    = 4;
  localparam int BIN_W     = 3;
  localparam int BINS      = 5;
  localparam int ACC_W     = AMP_WIDTH + $clog2(CELLS);
  localparam int CMP_W     = (AMP_WIDTH > CFG_W) ? AMP_WIDTH : CFG_W;
  localparam int WIDE_W    = 40;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic signed [CFG_W-1:0] BAD_THRESHOLD_RST = CFG_W'(-50);
  localparam logic signed [CFG_W-1:0] MAX_FLOOR_RST     = CFG_W'(-999);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAD_THRESHOLD,
    REG_MAX_FLOOR
  } reg_idx_t;

  typedef struct packed {
    logic                        we;
    logic [ADDR_W-1:0]           addr;
    logic signed [AMP_WIDTH-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic                    centre_ok;
    logic [RC_W-1:0]         centre_row;
    logic [RC_W-1:0]         centre_col;
    logic [IDX_W-1:0]        max_index;
    logic signed [ACC_W-1:0] whole_sum;
    logic                    any_bad;
  } job_t;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    w  = WIDE_W'(v);
    hi = (WIDE_W'(1) <<< (SUM_W - 1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (w > hi) return SUM_W'(hi);
    if (w < lo) return SUM_W'(lo);
    return SUM_W'(w);
  endfunction

  function automatic logic signed [S1_W-1:0] sat_amp(input logic signed [ACC_W-1:0] v);
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    w  = WIDE_W'(v);
    hi = (WIDE_W'(1) <<< (S1_W - 1)) - WIDE_W'(1);
    lo = -hi - WIDE_W'(1);
    if (w > hi) return S1_W'(hi);
    if (w < lo) return S1_W'(lo);
    return S1_W'(w);
  endfunction

endpackage

[rtl/ccs_if.sv]
// stream interfaces for crystal items and cluster results
interface ccs_in_if import ccs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [AMP_WIDTH-1:0] amplitude;
  logic                        last;
  logic                        use_max;
  logic [IDX_W-1:0]            center_index;

  modport source(output valid, amplitude, last, use_max, center_index, input ready);
  modport sink(input valid, amplitude, last, use_max, center_index, output ready);
endinterface

interface ccs_out_if import ccs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        max_index;
  logic signed [S1_W-1:0]  sum_1x1;
  logic signed [SUM_W-1:0] sum_3x3;
  logic signed [SUM_W-1:0] sum_5x5;
  logic signed [SUM_W-1:0] sum_7x7;
  logic [FLAG_W-1:0]       bad_flags;
  logic [BIN_W-1:0]        bin_index;
  logic signed [SUM_W-1:0] column_sum;
  logic signed [SUM_W-1:0] row_sum;
  logic                    last_result;

  modport source(output valid, max_index, sum_1x1, sum_3x3, sum_5x5, sum_7x7, bad_flags,
                 bin_index, column_sum, row_sum, last_result, input ready);
  modport sink(input valid, max_index, sum_1x1, sum_3x3, sum_5x5, sum_7x7, bad_flags,
               bin_index, column_sum, row_sum, last_result, output ready);
endinterface

[rtl/calorimeter_cluster_sums.sv]
// top level of the calorimeter cluster sum block
//
// in_item carries one crystal amplitude per transfer, 49 per event in row-major
// order of a 7x7 grid; last marks the final crystal and brings use_max and
// center_index. the front stores each crystal in a 49-entry ram and tracks the
// first maximum, the whole-grid sum and the bad-channel flag as it goes, taking
// one crystal per cycle while in_item.ready is high. on last it queues a job and holds in_item.ready low
// while the back sweeps the ram.
// the back reads one crystal per cycle through the ram's registered read port:
// it takes the job, issues 49 reads, waits out the read register and finishes,
// after which the first result appears. results leave through registered
// outputs, one per cycle while out_res.ready is high; the front takes the next
// event during that time, though not while the back sweeps the ram. a stall
// on out_res holds the current result and, after the next event is loaded,
// in_item as well. reset puts bad_threshold to -50 and max_floor to -999 and
// empties the queue; the ram is not cleared. configuration is written through
// cfg_we, cfg_index, cfg_data; the user writes it only while the block is
// idle, which the block itself does not enforce.
module calorimeter_cluster_sums import ccs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ccs_in_if.sink               in_item,
  ccs_out_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic signed [CFG_W-1:0] bad_threshold_r;
  logic signed [CFG_W-1:0] max_floor_r;

  job_t                  push_job;
  job_t                  pop_job;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic                  release_store;
  ram_wr_t               ram_wr;
  logic [ADDR_W-1:0]     ram_rd_addr;
  logic [AMP_WIDTH-1:0]  ram_rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_threshold_r <= BAD_THRESHOLD_RST;
      max_floor_r     <= MAX_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BAD_THRESHOLD: bad_threshold_r <= cfg_data;
        REG_MAX_FLOOR:     max_floor_r     <= cfg_data;
      endcase
    end
  end

  // front: store, running maximum, whole sum, bad flag
  ccs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .bad_threshold (bad_threshold_r),
    .max_floor     (max_floor_r),
    .release_store (release_store),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job),
    .ram_wr        (ram_wr)
  );

  // crystal store shared by front (write) and back (read)
  ccs_ram #(
    .WIDTH (AMP_WIDTH),
    .DEPTH (CELLS)
  ) u_grid_ram (
    .clk     (clk),
    .we      (ram_wr.we),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // event jobs waiting for the back
  ccs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: window and profile sums, result transfers
  ccs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data),
    .bad_threshold (bad_threshold_r),
    .release_store (release_store),
    .out_res       (out_res)
  );

`ifndef NO_ASSERTIONS
  // a job is never offered to a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // while the back finishes its sweep the store stays locked against new crystals
  a_store_locked: assert property (@(posedge clk) disable iff (!rst_n)
    release_store |-> !in_item.ready)
    else $error("input open while store still being read");

  // the event's closing result carries the final profile bin
  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.last_result) |-> (out_res.bin_index == BIN_W'(BINS - 1)))
    else $error("last result on wrong bin");
`endif

endmodule

[rtl/ccs_ram.sv]
// generic single-write, single-read ram with registered read data
module ccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 49
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/ccs_front.sv]
// front end: stores crystals, tracks maximum, whole sum and bad channels
module ccs_front import ccs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  ccs_in_if.sink                  in_item,
  input  logic signed [CFG_W-1:0] bad_threshold,
  input  logic signed [CFG_W-1:0] max_floor,
  input  logic                    release_store,
  input  logic                    q_full,
  output logic                    q_push,
  output job_t                    q_job,
  output ram_wr_t                 ram_wr
);

  function automatic logic [RC_W-1:0] idx_row(input logic [IDX_W-1:0] idx);
    logic [RC_W-1:0] r;
    r = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (idx >= IDX_W'(k * GRID_SIDE)) r = RC_W'(k);
    end
    return r;
  endfunction

  logic [CNT_W-1:0]        wc_r;
  logic [RC_W-1:0]         wr_row_r;
  logic [RC_W-1:0]         wr_col_r;
  logic signed [CMP_W-1:0] best_value_r;
  logic [IDX_W-1:0]        best_index_r;
  logic [RC_W-1:0]         best_row_r;
  logic [RC_W-1:0]         best_col_r;
  logic signed [ACC_W-1:0] whole_r;
  logic                    any_bad_r;
  logic                    busy_r;

  logic                    accept;
  logic                    store_ok;
  logic                    first;
  logic                    take;
  logic signed [CMP_W-1:0] amp_x;
  logic signed [CMP_W-1:0] cur_best;
  logic signed [CMP_W-1:0] best_value_nxt;
  logic [IDX_W-1:0]        best_index_nxt;
  logic [RC_W-1:0]         best_row_nxt;
  logic [RC_W-1:0]         best_col_nxt;
  logic signed [ACC_W-1:0] whole_nxt;
  logic                    any_bad_nxt;
  logic [RC_W-1:0]         ci_row;
  logic [RC_W-1:0]         ci_col;
  logic [IDX_W-1:0]        ci_base;

  assign in_item.ready = !busy_r && !q_full;
  assign accept        = in_item.valid && in_item.ready;
  assign store_ok      = wc_r < CNT_W'(CELLS);
  assign first         = wc_r == '0;
  assign amp_x         = CMP_W'(in_item.amplitude);

  always_comb begin
    cur_best       = first ? CMP_W'(max_floor) : best_value_r;
    take           = amp_x > cur_best;
    best_value_nxt = take ? amp_x : cur_best;
    best_index_nxt = take ? IDX_W'(wc_r) : (first ? IDX_W'(CELLS) : best_index_r);
    best_row_nxt   = take ? wr_row_r : best_row_r;
    best_col_nxt   = take ? wr_col_r : best_col_r;
    whole_nxt      = (first ? '0 : whole_r) + ACC_W'(in_item.amplitude);
    any_bad_nxt    = (!first && any_bad_r) || (amp_x < CMP_W'(bad_threshold));
  end

  // explicit centre: row by compare table, column by remainder
  assign ci_row  = idx_row(in_item.center_index);
  assign ci_base = IDX_W'(ci_row * GRID_SIDE);
  assign ci_col  = RC_W'(in_item.center_index - ci_base);

  assign q_push = accept && store_ok && in_item.last;

  always_comb begin
    q_job.max_index = best_index_nxt;
    q_job.whole_sum = whole_nxt;
    q_job.any_bad   = any_bad_nxt;
    if (in_item.use_max) begin
      q_job.centre_ok  = best_index_nxt != IDX_W'(CELLS);
      q_job.centre_row = best_row_nxt;
      q_job.centre_col = best_col_nxt;
    end else begin
      q_job.centre_ok  = in_item.center_index < IDX_W'(CELLS);
      q_job.centre_row = ci_row;
      q_job.centre_col = ci_col;
    end
  end

  assign ram_wr.we   = accept && store_ok;
  assign ram_wr.addr = wc_r[ADDR_W-1:0];
  assign ram_wr.data = in_item.amplitude;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r     <= '0;
      wr_row_r <= '0;
      wr_col_r <= '0;
      busy_r   <= 1'b0;
    end else begin
      if (q_push) begin
        busy_r <= 1'b1;
      end else if (release_store) begin
        busy_r <= 1'b0;
      end
      if (accept && store_ok) begin
        best_value_r <= best_value_nxt;
        best_index_r <= best_index_nxt;
        best_row_r   <= best_row_nxt;
        best_col_r   <= best_col_nxt;
        whole_r      <= whole_nxt;
        any_bad_r    <= any_bad_nxt;
        if (in_item.last) begin
          wc_r     <= '0;
          wr_row_r <= '0;
          wr_col_r <= '0;
        end else begin
          wc_r <= wc_r + CNT_W'(1);
          if (wr_col_r == RC_W'(GRID_SIDE - 1)) begin
            wr_col_r <= '0;
            wr_row_r <= wr_row_r + RC_W'(1);
          end else begin
            wr_col_r <= wr_col_r + RC_W'(1);
          end
        end
      end
    end
  end

endmodule

[rtl/ccs_queue.sv]
// short job queue between front and back
module ccs_queue import ccs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/ccs_back.sv]
// back end: sweeps the stored grid for window and profile sums, emits results
module ccs_back import ccs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  job_t                    q_job,
  output logic                    q_pop,
  output logic [ADDR_W-1:0]       ram_rd_addr,
  input  logic [AMP_WIDTH-1:0]    ram_rd_data,
  input  logic signed [CFG_W-1:0] bad_threshold,
  output logic                    release_store,
  ccs_out_if.source               out_res
);

  typedef enum logic [1:0] {B_IDLE, B_SWEEP, B_FINISH, B_EMIT} bstate_t;

  localparam logic [RC_W+1:0] HALF0 = (RC_W + 2)'(0);
  localparam logic [RC_W+1:0] HALF1 = (RC_W + 2)'(1);
  localparam logic [RC_W+1:0] HALF2 = (RC_W + 2)'(2);

  function automatic logic in_win(input logic [RC_W-1:0] r, input logic [RC_W-1:0] c,
                                  input logic [RC_W-1:0] cr, input logic [RC_W-1:0] cc,
                                  input logic [RC_W+1:0] h);
    logic [RC_W+1:0] re;
    logic [RC_W+1:0] ce;
    logic [RC_W+1:0] cre;
    logic [RC_W+1:0] cce;
    re  = (RC_W + 2)'(r);
    ce  = (RC_W + 2)'(c);
    cre = (RC_W + 2)'(cr);
    cce = (RC_W + 2)'(cc);
    return (re + h >= cre) && (re <= cre + h) && (ce + h >= cce) && (ce <= cce + h);
  endfunction

  function automatic logic off_grid(input logic [RC_W-1:0] cr, input logic [RC_W-1:0] cc,
                                    input logic [RC_W+1:0] h);
    logic [RC_W+1:0] cre;
    logic [RC_W+1:0] cce;
    cre = (RC_W + 2)'(cr);
    cce = (RC_W + 2)'(cc);
    return (cre < h) || (cce < h) || (cre + h >= (RC_W + 2)'(GRID_SIDE)) ||
           (cce + h >= (RC_W + 2)'(GRID_SIDE));
  endfunction

  bstate_t                 state_r;
  logic [RC_W-1:0]         cr_r;
  logic [RC_W-1:0]         cc_r;
  logic [IDX_W-1:0]        max_index_r;
  logic signed [ACC_W-1:0] whole_r;
  logic                    any_bad_r;
  logic [ADDR_W-1:0]       iss_addr_r;
  logic [RC_W-1:0]         iss_row_r;
  logic [RC_W-1:0]         iss_col_r;
  logic                    iss_done_r;
  logic                    rd_valid_r;
  logic                    rd_last_r;
  logic [RC_W-1:0]         rd_row_r;
  logic [RC_W-1:0]         rd_col_r;
  logic signed [ACC_W-1:0] acc1_r;
  logic signed [ACC_W-1:0] acc3_r;
  logic signed [ACC_W-1:0] acc5_r;
  logic                    f1_r;
  logic                    f3_r;
  logic                    f5_r;
  logic signed [ACC_W-1:0] col_acc_r [BINS];
  logic signed [ACC_W-1:0] row_acc_r [BINS];
  logic                    out_valid_r;
  logic signed [S1_W-1:0]  s1_out_r;
  logic signed [SUM_W-1:0] s3_out_r;
  logic signed [SUM_W-1:0] s5_out_r;
  logic signed [SUM_W-1:0] s7_out_r;
  logic [FLAG_W-1:0]       flags_out_r;
  logic [BIN_W-1:0]        bin_r;
  logic signed [SUM_W-1:0] col_out_r [BINS];
  logic signed [SUM_W-1:0] row_out_r [BINS];

  logic signed [ACC_W-1:0] a;
  logic                    a_bad;
  logic                    w1;
  logic                    w3;
  logic                    w5;
  logic                    prow_ok;
  logic                    pcol_ok;

  assign a       = ACC_W'($signed(ram_rd_data));
  assign a_bad   = CMP_W'($signed(ram_rd_data)) < CMP_W'(bad_threshold);
  assign w1      = in_win(rd_row_r, rd_col_r, cr_r, cc_r, HALF0);
  assign w3      = in_win(rd_row_r, rd_col_r, cr_r, cc_r, HALF1);
  assign w5      = in_win(rd_row_r, rd_col_r, cr_r, cc_r, HALF2);
  assign prow_ok = (rd_row_r >= RC_W'(1)) && (rd_row_r <= RC_W'(BINS));
  assign pcol_ok = (rd_col_r >= RC_W'(1)) && (rd_col_r <= RC_W'(BINS));

  assign q_pop         = (state_r == B_IDLE) && !q_empty;
  assign release_store = state_r == B_FINISH;
  assign ram_rd_addr   = iss_addr_r;

  assign out_res.valid       = out_valid_r;
  assign out_res.max_index   = max_index_r;
  assign out_res.sum_1x1     = s1_out_r;
  assign out_res.sum_3x3     = s3_out_r;
  assign out_res.sum_5x5     = s5_out_r;
  assign out_res.sum_7x7     = s7_out_r;
  assign out_res.bad_flags   = flags_out_r;
  assign out_res.bin_index   = bin_r;
  assign out_res.column_sum  = col_out_r[0];
  assign out_res.row_sum     = row_out_r[0];
  assign out_res.last_result = bin_r == BIN_W'(BINS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      rd_valid_r  <= 1'b0;
      iss_done_r  <= 1'b1;
      iss_addr_r  <= '0;
    end else begin
      rd_valid_r <= (state_r == B_SWEEP) && !iss_done_r;
      rd_last_r  <= iss_addr_r == ADDR_W'(CELLS - 1);
      rd_row_r   <= iss_row_r;
      rd_col_r   <= iss_col_r;

      // one stored crystal per cycle into every sum that covers it
      if (rd_valid_r) begin
        if (w1) acc1_r <= acc1_r + a;
        if (w3) acc3_r <= acc3_r + a;
        if (w5) acc5_r <= acc5_r + a;
        f1_r <= f1_r || (w1 && a_bad);
        f3_r <= f3_r || (w3 && a_bad);
        f5_r <= f5_r || (w5 && a_bad);
        for (int j = 0; j < BINS; j++) begin
          if (prow_ok && rd_col_r == RC_W'(j + 1)) col_acc_r[j] <= col_acc_r[j] + a;
          if (pcol_ok && rd_row_r == RC_W'(j + 1)) row_acc_r[j] <= row_acc_r[j] + a;
        end
      end

      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            cr_r        <= q_job.centre_row;
            cc_r        <= q_job.centre_col;
            max_index_r <= q_job.max_index;
            whole_r     <= q_job.whole_sum;
            any_bad_r   <= q_job.any_bad;
            f1_r        <= !q_job.centre_ok;
            f3_r        <= !q_job.centre_ok ||
                           off_grid(q_job.centre_row, q_job.centre_col, HALF1);
            f5_r        <= !q_job.centre_ok ||
                           off_grid(q_job.centre_row, q_job.centre_col, HALF2);
            acc1_r      <= '0;
            acc3_r      <= '0;
            acc5_r      <= '0;
            for (int j = 0; j < BINS; j++) begin
              col_acc_r[j] <= '0;
              row_acc_r[j] <= '0;
            end
            iss_addr_r <= '0;
            iss_row_r  <= '0;
            iss_col_r  <= '0;
            iss_done_r <= 1'b0;
            state_r    <= B_SWEEP;
          end
        end
        B_SWEEP: begin
          if (!iss_done_r) begin
            if (iss_addr_r == ADDR_W'(CELLS - 1)) begin
              iss_done_r <= 1'b1;
            end else begin
              iss_addr_r <= iss_addr_r + ADDR_W'(1);
            end
            if (iss_col_r == RC_W'(GRID_SIDE - 1)) begin
              iss_col_r <= '0;
              iss_row_r <= iss_row_r + RC_W'(1);
            end else begin
              iss_col_r <= iss_col_r + RC_W'(1);
            end
          end
          if (rd_valid_r && rd_last_r) begin
            state_r <= B_FINISH;
          end
        end
        B_FINISH: begin
          s1_out_r    <= f1_r ? '0 : sat_amp(acc1_r);
          s3_out_r    <= f3_r ? '0 : sat_sum(acc3_r);
          s5_out_r    <= f5_r ? '0 : sat_sum(acc5_r);
          s7_out_r    <= any_bad_r ? '0 : sat_sum(whole_r);
          flags_out_r <= {any_bad_r, f5_r, f3_r, f1_r};
          for (int j = 0; j < BINS; j++) begin
            col_out_r[j] <= sat_sum(col_acc_r[j]);
            row_out_r[j] <= sat_sum(row_acc_r[j]);
          end
          bin_r       <= '0;
          out_valid_r <= 1'b1;
          state_r     <= B_EMIT;
        end
        B_EMIT: begin
          if (out_res.ready) begin
            for (int j = 0; j < BINS - 1; j++) begin
              col_out_r[j] <= col_out_r[j + 1];
              row_out_r[j] <= row_out_r[j + 1];
            end
            bin_r <= bin_r + BIN_W'(1);
            if (bin_r == BIN_W'(BINS - 1)) begin
              out_valid_r <= 1'b0;
              state_r     <= B_IDLE;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
